>>> hw/rtl/mkds_pkg.sv
// ============================================================================
// Matrix keypad scanner package
// Shared types, field widths, register indexes and debounce phase codes.
// ============================================================================
package mkds_pkg;

    localparam int ROW_COUNT_DEF    = 4;
    localparam int COLUMN_COUNT_DEF = 4;

    localparam int ROW_W    = 2;
    localparam int LEVEL_W  = 4;
    localparam int TIME_W   = 32;
    localparam int KEY_W    = 4;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 32;

    localparam int S_TDATA_W = 40;
    localparam int M_TDATA_W = 8;

    localparam int QUEUE_DEPTH = 2;

    localparam logic [CFG_IDX_W-1:0] CFG_PRESS_HOLD   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_RELEASE_HOLD = 2'd1;

    localparam logic [TIME_W-1:0] PRESS_HOLD_RST   = 32'd10000;
    localparam logic [TIME_W-1:0] RELEASE_HOLD_RST = 32'd100000;

    // per-key debounce phases
    localparam logic [1:0] PH_RELEASED     = 2'd0;
    localparam logic [1:0] PH_CONF_PRESS   = 2'd1;
    localparam logic [1:0] PH_PRESSED      = 2'd2;
    localparam logic [1:0] PH_CONF_RELEASE = 2'd3;

    typedef struct packed {
        logic [TIME_W-1:0]  time_us;
        logic [LEVEL_W-1:0] column_levels;
        logic [ROW_W-1:0]   row_index;
    } scan_t;

    typedef struct packed {
        logic [TIME_W-1:0] press_hold;
        logic [TIME_W-1:0] release_hold;
    } hold_cfg_t;

endpackage

>>> hw/rtl/mkds_front.sv
// ============================================================================
// Keypad scanner front end
// Takes row scan beats, drops rows outside the matrix, hands the rest on.
// ============================================================================
module mkds_front
    import mkds_pkg::*;
#(
    parameter int ROW_COUNT = ROW_COUNT_DEF
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_valid,
    output logic                 s_ready,
    input  scan_t                s_item,
    output logic                 q_push,
    input  logic                 q_ready,
    output scan_t                q_item
);

    logic  valid_reg;
    logic  in_range_reg;
    scan_t item_reg;
    logic  advance;
    logic  take;

    // out-of-range rows leave without touching the queue
    assign advance = valid_reg && (!in_range_reg || q_ready);
    assign s_ready = !valid_reg || advance;
    assign take    = s_valid && s_ready;
    assign q_push  = valid_reg && in_range_reg && q_ready;
    assign q_item  = item_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (take) begin
            valid_reg <= 1'b1;
        end else if (advance) begin
            valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (take) begin
            item_reg     <= s_item;
            in_range_reg <= (32'(s_item.row_index) < ROW_COUNT);
        end
    end

endmodule

>>> hw/rtl/mkds_queue.sv
// ============================================================================
// Keypad scanner scan queue
// Short FIFO between front end and debounce engine.
// ============================================================================
module mkds_queue
    import mkds_pkg::*;
(
    input  logic  aclk,
    input  logic  aresetn,
    input  logic  push,
    output logic  push_ready,
    input  scan_t push_item,
    input  logic  pop,
    output logic  pop_valid,
    output scan_t pop_item
);

    localparam int PTR_W = $clog2(QUEUE_DEPTH);
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

    scan_t            slot_reg [QUEUE_DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg;
    logic [PTR_W-1:0] rd_ptr_reg;
    logic [CNT_W-1:0] count_reg;
    logic             do_push;
    logic             do_pop;

    assign push_ready = (count_reg != CNT_W'(QUEUE_DEPTH));
    assign pop_valid  = (count_reg != '0);
    assign pop_item   = slot_reg[rd_ptr_reg];
    assign do_push    = push && push_ready;
    assign do_pop     = pop && pop_valid;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            if (do_push) begin
                wr_ptr_reg <= (wr_ptr_reg == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
            end
            if (do_pop) begin
                rd_ptr_reg <= (rd_ptr_reg == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
            end
            if (do_push && !do_pop) begin
                count_reg <= count_reg + 1'b1;
            end else if (do_pop && !do_push) begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (do_push) begin
            slot_reg[wr_ptr_reg] <= push_item;
        end
    end

endmodule

>>> hw/rtl/mkds_back.sv
// ============================================================================
// Keypad scanner debounce engine
// Updates the scanned row's keys up to and including the first newly confirmed press, and emits that press.
// ============================================================================
module mkds_back
    import mkds_pkg::*;
#(
    parameter int ROW_COUNT    = ROW_COUNT_DEF,
    parameter int COLUMN_COUNT = COLUMN_COUNT_DEF
) (
    input  logic             aclk,
    input  logic             aresetn,
    input  hold_cfg_t        hold_cfg,
    input  logic             q_valid,
    output logic             q_pop,
    input  scan_t            q_item,
    output logic             m_valid,
    input  logic             m_ready,
    output logic [KEY_W-1:0] m_key
);

    // row_index is two bits wide, so at most four rows can ever be scanned
    localparam int STORED_ROWS = (ROW_COUNT < 4) ? ROW_COUNT : 4;
    localparam int RIDX_W      = (STORED_ROWS > 1) ? $clog2(STORED_ROWS) : 1;

    logic [1:0]        phase_reg   [STORED_ROWS][COLUMN_COUNT];
    logic [TIME_W-1:0] pstamp_reg  [STORED_ROWS][COLUMN_COUNT];
    logic [TIME_W-1:0] rstamp_reg  [STORED_ROWS][COLUMN_COUNT];

    logic              m_valid_reg;
    logic [KEY_W-1:0]  key_reg;

    logic [RIDX_W-1:0]       row;
    logic [COLUMN_COUNT-1:0] high;
    logic [1:0]              ph_next   [COLUMN_COUNT];
    logic [COLUMN_COUNT-1:0] set_pstamp;
    logic [COLUMN_COUNT-1:0] set_rstamp;
    logic [COLUMN_COUNT-1:0] confirm;
    logic [COLUMN_COUNT-1:0] upd_en;
    logic                    any_confirm;
    logic [7:0]              code_wide;

    assign row     = q_item.row_index[RIDX_W-1:0];
    assign q_pop   = q_valid && (!m_valid_reg || m_ready);
    assign m_valid = m_valid_reg;
    assign m_key   = key_reg;

    always_comb begin
        logic [1:0]        ph;
        logic [TIME_W-1:0] p_age;
        logic [TIME_W-1:0] r_age;
        logic              blocked;
        any_confirm = 1'b0;
        code_wide   = '0;
        blocked     = 1'b0;
        for (int j = 0; j < COLUMN_COUNT; j++) begin
            // columns with no level bit read as not pressed
            high[j]       = (j < LEVEL_W) ? q_item.column_levels[j % LEVEL_W] : 1'b1;
            ph            = phase_reg[row][j];
            p_age         = q_item.time_us - pstamp_reg[row][j];
            r_age         = q_item.time_us - rstamp_reg[row][j];
            ph_next[j]    = ph;
            set_pstamp[j] = 1'b0;
            set_rstamp[j] = 1'b0;
            confirm[j]    = 1'b0;
            if (high[j]) begin
                if (ph == PH_PRESSED) begin
                    set_rstamp[j] = 1'b1;
                    ph_next[j]    = PH_CONF_RELEASE;
                end else if (ph == PH_CONF_RELEASE) begin
                    if (r_age >= hold_cfg.release_hold) begin
                        ph_next[j] = PH_RELEASED;
                    end
                end else begin
                    ph_next[j] = PH_RELEASED;
                end
            end else begin
                if (ph == PH_RELEASED) begin
                    set_pstamp[j] = 1'b1;
                    ph_next[j]    = PH_CONF_PRESS;
                end else if (ph == PH_CONF_PRESS) begin
                    if (p_age >= hold_cfg.press_hold) begin
                        ph_next[j] = PH_PRESSED;
                        confirm[j] = 1'b1;
                    end
                end else begin
                    ph_next[j] = PH_PRESSED;
                end
            end
            // columns past the first confirmed press keep their state
            upd_en[j] = !blocked;
            if (confirm[j] && !blocked) begin
                any_confirm = 1'b1;
                code_wide   = 8'(32'(row) * COLUMN_COUNT + j);
            end
            blocked = blocked | confirm[j];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int r = 0; r < STORED_ROWS; r++) begin
                for (int j = 0; j < COLUMN_COUNT; j++) begin
                    phase_reg[r][j] <= PH_RELEASED;
                end
            end
        end else if (q_pop) begin
            for (int j = 0; j < COLUMN_COUNT; j++) begin
                if (upd_en[j]) begin
                    phase_reg[row][j] <= ph_next[j];
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (q_pop) begin
            for (int j = 0; j < COLUMN_COUNT; j++) begin
                if (upd_en[j] && set_pstamp[j]) begin
                    pstamp_reg[row][j] <= q_item.time_us;
                end
                if (upd_en[j] && set_rstamp[j]) begin
                    rstamp_reg[row][j] <= q_item.time_us;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (q_pop && any_confirm) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (q_pop && any_confirm) begin
            key_reg <= code_wide[KEY_W-1:0];
        end
    end

endmodule

>>> hw/rtl/matrix_keypad_debounce_scanner.sv
// ============================================================================
// Matrix keypad debounce scanner
// Per-key debounce of row scans from a key matrix; reports confirmed presses.
// ============================================================================
//  channel  | dir | handshake               | payload
//  ---------+-----+-------------------------+-----------------------------------
//  s_axis   | in  | s_axis_tvalid / tready  | tdata: row_index, column_levels,
//           |     |                         |        time_us
//  m_axis   | out | m_axis_tvalid / tready  | tdata: key_code
//  cfg      | in  | cfg_wr_en               | cfg_index, cfg_data
//
//  One scan beat per cycle sustained while m_axis is not stalled. A beat is
//  held in the front register, then written into the queue; the row update
//  and any key code with m_axis_tvalid are registered when it is popped.
//  The row update (per-column 32-bit age compare) is combinational.
//  Reset puts every key in the released phase and loads the default holds.
//  While m_axis stalls the front register and two-entry queue absorb up to
//  three beats before s_axis_tready drops.
// ============================================================================
module matrix_keypad_debounce_scanner
    import mkds_pkg::*;
#(
    parameter int ROW_COUNT    = ROW_COUNT_DEF,
    parameter int COLUMN_COUNT = COLUMN_COUNT_DEF
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_axis_tvalid,
    output logic                  s_axis_tready,
    input  logic [S_TDATA_W-1:0]  s_axis_tdata,   // row_index, column_levels, time_us
    output logic                  m_axis_tvalid,
    input  logic                  m_axis_tready,
    output logic [M_TDATA_W-1:0]  m_axis_tdata,   // key_code
    input  logic                  cfg_wr_en,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data
);

    localparam int ITEM_W = ROW_W + LEVEL_W + TIME_W;

    logic [TIME_W-1:0] press_hold_reg;
    logic [TIME_W-1:0] release_hold_reg;
    hold_cfg_t         hold_cfg;

    scan_t            s_item;
    logic             q_push;
    logic             q_ready;
    scan_t            q_in_item;
    logic             q_pop;
    logic             q_valid;
    scan_t            q_out_item;
    logic [KEY_W-1:0] m_key;

    assign s_item = scan_t'(s_axis_tdata[ITEM_W-1:0]);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            press_hold_reg   <= PRESS_HOLD_RST;
            release_hold_reg <= RELEASE_HOLD_RST;
        end else if (cfg_wr_en) begin
            case (cfg_index)
                CFG_PRESS_HOLD:   press_hold_reg   <= cfg_data[TIME_W-1:0];
                CFG_RELEASE_HOLD: release_hold_reg <= cfg_data[TIME_W-1:0];
                default: ;
            endcase
        end
    end

    assign hold_cfg.press_hold   = press_hold_reg;
    assign hold_cfg.release_hold = release_hold_reg;

    mkds_front #(
        .ROW_COUNT (ROW_COUNT)
    ) u_front (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_axis_tvalid),
        .s_ready (s_axis_tready),
        .s_item  (s_item),
        .q_push  (q_push),
        .q_ready (q_ready),
        .q_item  (q_in_item)
    );

    mkds_queue u_queue (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push       (q_push),
        .push_ready (q_ready),
        .push_item  (q_in_item),
        .pop        (q_pop),
        .pop_valid  (q_valid),
        .pop_item   (q_out_item)
    );

    mkds_back #(
        .ROW_COUNT    (ROW_COUNT),
        .COLUMN_COUNT (COLUMN_COUNT)
    ) u_back (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .hold_cfg (hold_cfg),
        .q_valid  (q_valid),
        .q_pop    (q_pop),
        .q_item   (q_out_item),
        .m_valid  (m_axis_tvalid),
        .m_ready  (m_axis_tready),
        .m_key    (m_key)
    );

    assign m_axis_tdata = {{(M_TDATA_W - KEY_W){1'b0}}, m_key};

endmodule

>>> bench/matrix_keypad_debounce_scanner_tb.sv
`timescale 1ns / 1ps
// ============================================================================
// Matrix keypad debounce scanner testbench
// Streams row-scan beats into the scanner and checks every reported key code
// against a per-key debounce predictor kept in step with the hold registers.
// Directed scans cover the hold edges, timestamp wrap and contact bounce.
// Random runs cycle the rows with held keys and bounce, under several hold
// settings, with random idle bursts on both streams in all but the last run.
// ============================================================================
module matrix_keypad_debounce_scanner_tb;
    import mkds_pkg::*;

    localparam int KEY_TOTAL   = ROW_COUNT_DEF * COLUMN_COUNT_DEF;
    localparam int CYCLE_LIMIT = 300000;
    localparam int SETTLE      = 8;

    // indexes with no register behind them
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE_A = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE_B = 2'd3;

    logic                  aclk;
    logic                  aresetn       = 1'b0;
    logic                  s_axis_tvalid = 1'b0;
    logic                  s_axis_tready;
    logic [S_TDATA_W-1:0]  s_axis_tdata  = '0;   // row_index, column_levels, time_us
    logic                  m_axis_tvalid;
    logic                  m_axis_tready = 1'b0;
    logic [M_TDATA_W-1:0]  m_axis_tdata;         // key_code
    logic                  cfg_wr_en     = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_index     = '0;
    logic [CFG_DATA_W-1:0] cfg_data      = '0;

    matrix_keypad_debounce_scanner dut (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .cfg_wr_en     (cfg_wr_en),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data)
    );

    // predictor state
    logic [1:0]        key_ph     [KEY_TOTAL];
    logic [TIME_W-1:0] low_since  [KEY_TOTAL];
    logic [TIME_W-1:0] high_since [KEY_TOTAL];
    logic [TIME_W-1:0] press_hold   = PRESS_HOLD_RST;
    logic [TIME_W-1:0] release_hold = RELEASE_HOLD_RST;

    scan_t            scan_queue[$];
    logic [KEY_W-1:0] expected_keys[$];
    int unsigned      scans_queued = 0;
    int unsigned      scans_taken  = 0;
    int unsigned      fails        = 0;

    bit          bursts_on  = 1'b1;
    int unsigned src_gap    = 0;
    int unsigned sink_stall = 0;

    // random scan generator state
    logic [TIME_W-1:0]  scan_clock = '0;
    logic [ROW_W-1:0]   next_row   = '0;
    logic [LEVEL_W-1:0] held_cols [ROW_COUNT_DEF];

    initial begin
        for (int k = 0; k < KEY_TOTAL; k++) begin
            key_ph[k]     = PH_RELEASED;
            low_since[k]  = '0;
            high_since[k] = '0;
        end
        for (int r = 0; r < ROW_COUNT_DEF; r++)
            held_cols[r] = '1;
    end

    initial begin
        aclk = 1'b0;
        forever #2 aclk = ~aclk;
    end

    // one row scan through the debouncers; at most one newly confirmed key
    function automatic void debounce_scan(scan_t beat);
        int unsigned       key;
        logic              level_high;
        logic [TIME_W-1:0] age;
        if (beat.row_index >= ROW_COUNT_DEF)
            return;
        for (int col = 0; col < COLUMN_COUNT_DEF; col++) begin
            key        = beat.row_index * COLUMN_COUNT_DEF + col;
            level_high = (col >= LEVEL_W) ? 1'b1 : beat.column_levels[col];
            if (level_high) begin
                age = beat.time_us - high_since[key];
                case (key_ph[key])
                    PH_PRESSED: begin
                        high_since[key] = beat.time_us;
                        key_ph[key]     = PH_CONF_RELEASE;
                    end
                    PH_CONF_RELEASE: begin
                        if (age >= release_hold)
                            key_ph[key] = PH_RELEASED;
                    end
                    default: key_ph[key] = PH_RELEASED;
                endcase
            end else begin
                age = beat.time_us - low_since[key];
                case (key_ph[key])
                    PH_RELEASED: begin
                        low_since[key] = beat.time_us;
                        key_ph[key]    = PH_CONF_PRESS;
                    end
                    PH_CONF_PRESS: begin
                        if (age >= press_hold) begin
                            key_ph[key] = PH_PRESSED;
                            expected_keys.push_back(key[KEY_W-1:0]);
                            // rest of the row is skipped on a confirm
                            return;
                        end
                    end
                    default: key_ph[key] = PH_PRESSED;
                endcase
            end
        end
    endfunction

    // source side
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_axis_tvalid <= 1'b0;
        end else begin
            if (s_axis_tvalid && s_axis_tready) begin
                debounce_scan(scan_t'(s_axis_tdata[$bits(scan_t)-1:0]));
                scans_taken++;
            end
            if (!s_axis_tvalid || s_axis_tready) begin
                if (src_gap != 0) begin
                    src_gap--;
                    s_axis_tvalid <= 1'b0;
                end else if (bursts_on && $urandom_range(0, 7) == 0) begin
                    src_gap = $urandom_range(1, 18) - 1;
                    s_axis_tvalid <= 1'b0;
                end else if (scan_queue.size() != 0) begin
                    s_axis_tvalid <= 1'b1;
                    s_axis_tdata  <= S_TDATA_W'(scan_queue.pop_front());
                end else begin
                    s_axis_tvalid <= 1'b0;
                end
            end
        end
    end

    // result side
    logic [KEY_W-1:0] want_key;

    always @(posedge aclk) begin
        if (!aresetn) begin
            m_axis_tready <= 1'b0;
        end else begin
            if (m_axis_tvalid && m_axis_tready) begin
                if (expected_keys.size() == 0) begin
                    $error("key_code: expected none, got %0d", m_axis_tdata[KEY_W-1:0]);
                    fails++;
                end else begin
                    want_key = expected_keys.pop_front();
                    if (m_axis_tdata[KEY_W-1:0] !== want_key) begin
                        $error("key_code: expected %0d, got %0d",
                               want_key, m_axis_tdata[KEY_W-1:0]);
                        fails++;
                    end
                end
            end
            if (sink_stall != 0) begin
                sink_stall--;
                m_axis_tready <= 1'b0;
            end else if (bursts_on && $urandom_range(0, 7) == 0) begin
                sink_stall = $urandom_range(1, 18) - 1;
                m_axis_tready <= 1'b0;
            end else begin
                m_axis_tready <= 1'b1;
            end
        end
    end

    task automatic queue_scan(input logic [ROW_W-1:0] row, input logic [LEVEL_W-1:0] levels,
                              input logic [TIME_W-1:0] stamp);
        scan_t beat;
        beat.row_index     = row;
        beat.column_levels = levels;
        beat.time_us       = stamp;
        scan_queue.push_back(beat);
        scans_queued++;
    endtask

    // rows scanned in turn, keys held for a while, occasional bounce and noise
    task automatic queue_keypad_run(input int count, input int unsigned step_max);
        logic [LEVEL_W-1:0] levels;
        logic [TIME_W-1:0]  stamp;
        for (int i = 0; i < count; i++) begin
            if ($urandom_range(0, 7) == 0)
                next_row = ROW_W'($urandom_range(0, ROW_COUNT_DEF - 1));
            if ($urandom_range(0, 9) == 0) begin
                case ($urandom_range(0, 3))
                    0:       held_cols[next_row] = '1;
                    1, 2:    held_cols[next_row] = ~(4'b0001 << $urandom_range(0, 3));
                    default: held_cols[next_row] = LEVEL_W'($urandom_range(0, 15));
                endcase
            end
            levels = held_cols[next_row];
            if ($urandom_range(0, 9) == 0)
                levels ^= 4'b0001 << $urandom_range(0, 3);
            scan_clock += $urandom_range(0, step_max);
            stamp = scan_clock;
            if ($urandom_range(0, 19) == 0) begin
                levels = LEVEL_W'($urandom_range(0, 15));
                stamp  = $urandom();
            end
            queue_scan(next_row, levels, stamp);
            next_row = next_row + 1'b1;
        end
    endtask

    task automatic write_hold(input logic [CFG_IDX_W-1:0] idx, input logic [TIME_W-1:0] value);
        @(posedge aclk);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        if (idx == CFG_PRESS_HOLD)
            press_hold = value;
        else if (idx == CFG_RELEASE_HOLD)
            release_hold = value;
        @(posedge aclk);
        cfg_wr_en <= 1'b0;
    endtask

    task automatic wait_drained(input int unsigned tail);
        while (scans_taken != scans_queued || expected_keys.size() != 0)
            @(posedge aclk);
        repeat (tail) @(posedge aclk);
    endtask

    initial begin : watchdog
        int unsigned cycles;
        cycles = 0;
        while (cycles < CYCLE_LIMIT) begin
            @(posedge aclk);
            cycles++;
        end
        $display("FAILED: results differ");
        $finish;
    end

    initial begin
        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;

        // reset holds: confirm sequence, release, wrap, bounce
        queue_scan(0, 4'h0, 32'd0);
        queue_scan(0, 4'h0, 32'd9999);
        queue_scan(0, 4'h0, 32'd10000);
        queue_scan(0, 4'h0, 32'd10000);
        queue_scan(0, 4'h0, 32'd10000);
        queue_scan(0, 4'h0, 32'd10000);
        queue_scan(0, 4'hF, 32'd20000);
        queue_scan(0, 4'hF, 32'd119999);
        queue_scan(0, 4'hF, 32'd120000);
        queue_scan(3, 4'hE, 32'hFFFF_FFF0);
        queue_scan(3, 4'hE, 32'h0000_2700);
        queue_scan(3, 4'h7, 32'h0000_2700);
        queue_scan(3, 4'h5, 32'hFFFF_FFFF);
        queue_scan(2, 4'hE, 32'd100);
        queue_scan(2, 4'hF, 32'd200);
        queue_scan(2, 4'hE, 32'd300);
        queue_scan(2, 4'hE, 32'd10299);
        queue_scan(2, 4'hE, 32'd10300);
        queue_scan(1, 4'hA, 32'd0);
        queue_scan(1, 4'h0, 32'h8000_0000);
        scan_clock = 32'h0010_0000;
        queue_keypad_run(140, 4000);
        wait_drained(SETTLE);

        // zero holds: confirm on the next scan
        write_hold(CFG_PRESS_HOLD, '0);
        write_hold(CFG_RELEASE_HOLD, '0);
        queue_scan(1, 4'hF, 32'd5);
        queue_scan(1, 4'hF, 32'd5);
        queue_scan(1, 4'h0, 32'd5);
        queue_scan(1, 4'h0, 32'd5);
        queue_keypad_run(110, 3);
        wait_drained(SETTLE);

        // maximum holds: only a full wrap of the age confirms
        write_hold(CFG_PRESS_HOLD, '1);
        write_hold(CFG_RELEASE_HOLD, '1);
        queue_scan(2, 4'hB, 32'd1000);
        queue_scan(2, 4'hB, 32'd998);
        queue_scan(2, 4'hB, 32'd999);
        queue_keypad_run(60, 5);
        wait_drained(SETTLE);

        // writes to spare indexes must leave the holds alone
        write_hold(CFG_SPARE_A, $urandom());
        write_hold(CFG_SPARE_B, $urandom());
        write_hold(CFG_PRESS_HOLD, $urandom_range(10, 40));
        write_hold(CFG_RELEASE_HOLD, $urandom_range(20, 80));
        scan_clock = 32'hFFFF_F000;
        queue_keypad_run(150, 12);
        wait_drained(SETTLE);

        // closing stretch at full rate
        write_hold(CFG_PRESS_HOLD, $urandom_range(0, 15));
        write_hold(CFG_RELEASE_HOLD, $urandom_range(0, 15));
        bursts_on = 1'b0;
        queue_keypad_run(190, 6);
        wait_drained(16);

        if (fails == 0)
            $display("PASSED: all results match");
        else
            $display("FAILED: results differ");
        $finish;
    end

endmodule
